[sv/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue cell row.
// ----------------------------------------------------------------------------
`default_nettype none
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one-hot broadcast to every cell; only set for a legal, accepted operation
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } dq_op_t;

endpackage
`default_nettype wire

[sv/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of 32-bit values held in a row of shifting cells.
//
// channel  dir  tdata                                   tuser
// in_      in   [31:0] value                            [1:0] kind
// out_     out  [31:0] popped_value, [33:32] status,    -
//               [38:34] fill_level, [39] zero
//
// One transaction per cycle while in_tready is high: a cell row update and one output register.
// The rear value comes from an OR tree over the cell taps.
// Reset clears all occupied bits, the entry count and the output valid flag.
// in_tready drops only while a result is held and out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module double_ended_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // [31:0] popped_value, [33:32] status,
                                       // [38:34] fill_level, [39] zero
);
  import dq_pkg::*;

  kind_t             kind;
  dq_op_t            op;
  logic              in_fire;
  logic              full, empty;
  logic [DEPTH-1:0]  occ;
  logic [DATA_W-1:0] front_data, rear_data;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] pop_r, pop_nxt;
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  fill_r;

  assign kind      = kind_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = occ[DEPTH-1];
  assign empty     = !occ[0];

  always_comb begin
    op         = '0;
    count_nxt  = count_r;
    pop_nxt    = '0;
    status_nxt = ST_OK;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op.push_front = in_fire && (kind == KIND_PUSH_FRONT);
          op.push_rear  = in_fire && (kind == KIND_PUSH_REAR);
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          op.pop_front = in_fire && (kind == KIND_POP_FRONT);
          op.pop_rear  = in_fire && (kind == KIND_POP_REAR);
          pop_nxt      = (kind == KIND_POP_FRONT) ? front_data : rear_data;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign out_valid_nxt = in_fire ? 1'b1 : (out_valid_r && !out_tready);

  dq_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .push_value (in_tdata),
    .front_data (front_data),
    .rear_data  (rear_data),
    .occ        (occ)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pop_r    <= pop_nxt;
      status_r <= status_nxt;
      fill_r   <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, FILL_W'(fill_r), status_r, pop_r};

  a_count_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ) == int'(count_r))
    else $error("entry count differs from occupied cells");

  a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (occ & (occ + DEPTH'(1))) == '0)
    else $error("occupied cells not packed at the front");

  a_full_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR))
      |=> (out_tdata[33:32] == ST_FULL && out_tvalid))
    else $error("push on full not flagged");

  a_empty_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && empty && (kind == KIND_POP_FRONT || kind == KIND_POP_REAR))
      |=> (out_tdata[33:32] == ST_EMPTY && out_tdata[31:0] == '0))
    else $error("pop on empty not flagged");

endmodule
`default_nettype wire

[sv/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell
// One queue slot: holds a value and an occupied bit, shifts towards either
// neighbour and detects whether it is the rear slot.
// ----------------------------------------------------------------------------
`default_nettype none
module dq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_pkg::dq_op_t             op,
  input  wire logic [dq_pkg::DATA_W-1:0]  push_value,
  input  wire logic [dq_pkg::DATA_W-1:0]  left_data,
  input  wire logic                       left_valid,
  input  wire logic [dq_pkg::DATA_W-1:0]  right_data,
  input  wire logic                       right_valid,
  output logic      [dq_pkg::DATA_W-1:0]  data_o,
  output logic                            valid_o,
  output logic      [dq_pkg::DATA_W-1:0]  rear_tap_o
);
  import dq_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (op.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (op.push_rear) begin
      if (!valid_r && left_valid) begin
        data_nxt  = push_value;
        valid_nxt = 1'b1;
      end
    end else if (op.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (op.pop_rear) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o     = data_r;
  assign valid_o    = valid_r;
  assign rear_tap_o = (valid_r && !right_valid) ? data_r : '0;

endmodule
`default_nettype wire

[sv/dq_chain.sv]
// ----------------------------------------------------------------------------
// dq_chain
// Row of queue cells, front at cell 0; gathers the front and rear values and
// the occupancy vector.
// ----------------------------------------------------------------------------
`default_nettype none
module dq_chain (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_pkg::dq_op_t             op,
  input  wire logic [dq_pkg::DATA_W-1:0]  push_value,
  output logic      [dq_pkg::DATA_W-1:0]  front_data,
  output logic      [dq_pkg::DATA_W-1:0]  rear_data,
  output logic      [dq_pkg::DEPTH-1:0]   occ
);
  import dq_pkg::*;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic [DATA_W-1:0] rear_tap   [DEPTH];
  logic [DATA_W-1:0] left_data  [DEPTH];
  logic [DATA_W-1:0] right_data [DEPTH];
  logic [DEPTH-1:0]  left_valid;
  logic [DEPTH-1:0]  right_valid;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_data[i]   = (i == 0) ? push_value : cell_data[(i == 0) ? 0 : i - 1];
      left_valid[i]  = (i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1];
      right_data[i]  = (i == DEPTH - 1) ? '0 : cell_data[(i == DEPTH - 1) ? i : i + 1];
      right_valid[i] = (i == DEPTH - 1) ? 1'b0 : occ[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .push_value  (push_value),
      .left_data   (left_data[g]),
      .left_valid  (left_valid[g]),
      .right_data  (right_data[g]),
      .right_valid (right_valid[g]),
      .data_o      (cell_data[g]),
      .valid_o     (occ[g]),
      .rear_tap_o  (rear_tap[g])
    );
  end

  // at most one tap is non-zero; per-bit OR trees
  for (genvar b = 0; b < DATA_W; b++) begin : g_rear_bit
    logic [DEPTH-1:0] bit_col;
    for (genvar c = 0; c < DEPTH; c++) begin : g_col
      assign bit_col[c] = rear_tap[c][b];
    end
    assign rear_data[b] = |bit_col;
  end

  assign front_data = cell_data[0];

endmodule
`default_nettype wire
